### hdl/mips_subset_execute_unit_assert.svh
// ----------------------------------------------------------------------------
// mips_subset_execute_unit_assert.svh
// Assertion macros for the execute unit. Define NO_ASSERTIONS to drop them.
// ----------------------------------------------------------------------------
`ifndef MIPS_SUBSET_EXECUTE_UNIT_ASSERT_SVH
`define MIPS_SUBSET_EXECUTE_UNIT_ASSERT_SVH

`ifndef NO_ASSERTIONS
// Consequent must hold in the same cycle as the antecedent
`define MSEU_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mseu: same-cycle check failed");
// Consequent must hold in the cycle after the antecedent
`define MSEU_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mseu: next-cycle check failed");
`else
`define MSEU_ASSERT_NOW(label, ante, cons)
`define MSEU_ASSERT_NEXT(label, ante, cons)
`endif

`endif

### hdl/mseu_pkg.sv
// ----------------------------------------------------------------------------
// mseu_pkg
// Types and constants shared by the execute unit modules.
// ----------------------------------------------------------------------------
package mseu_pkg;

    // Architectural reset values and fixed codes
    localparam logic [31:0] RESET_PC       = 32'hbfc0_0000;
    localparam logic [31:0] RESET_GPR      = 32'hbead_beef;
    localparam logic [31:0] JUMP_REGION    = 32'hf000_0000;
    localparam int          SR_ISOLATE_BIT = 16;
    localparam logic [4:0]  COP0_MT        = 5'b00100;
    localparam logic [4:0]  LINK_REG       = 5'd31;
    localparam logic [4:0]  STATUS_REG     = 5'd12;
    localparam logic [4:0]  GPR_ZERO       = 5'd0;
    localparam int          GPR_COUNT      = 32;

    // Primary opcodes
    localparam logic [5:0] OP_SPECIAL  = 6'h00;
    localparam logic [5:0] OP_J        = 6'h02;
    localparam logic [5:0] OP_JAL      = 6'h03;
    localparam logic [5:0] OP_BNE      = 6'h05;
    localparam logic [5:0] OP_ADDI     = 6'h08;
    localparam logic [5:0] OP_ADDI_UNS = 6'h09;
    localparam logic [5:0] OP_ANDI     = 6'h0c;
    localparam logic [5:0] OP_ORI      = 6'h0d;
    localparam logic [5:0] OP_LUI      = 6'h0f;
    localparam logic [5:0] OP_COP0     = 6'h10;
    localparam logic [5:0] OP_LW       = 6'h23;
    localparam logic [5:0] OP_SB       = 6'h28;
    localparam logic [5:0] OP_SH       = 6'h29;
    localparam logic [5:0] OP_SW       = 6'h2b;

    // SPECIAL function codes
    localparam logic [5:0] FN_SLL  = 6'h00;
    localparam logic [5:0] FN_JR   = 6'h08;
    localparam logic [5:0] FN_ADDU = 6'h21;
    localparam logic [5:0] FN_OR   = 6'h25;
    localparam logic [5:0] FN_SLTU = 6'h2b;

    typedef enum logic [2:0] {
        MEM_NONE = 3'd0,
        MEM_LW   = 3'd1,
        MEM_SW   = 3'd2,
        MEM_SH   = 3'd3,
        MEM_SB   = 3'd4
    } mem_op_t;

    // Input item
    typedef struct packed {
        logic [31:0] fetch_word;
        logic [31:0] load_data;
    } cmd_t;

    // Result item
    typedef struct packed {
        logic [31:0] fetch_addr;
        mem_op_t     mem_op;
        logic [31:0] mem_addr;
        logic [31:0] store_data;
        logic        fault;
    } rsp_t;

    // Register file writes in one step: bank A for instructions, bank B for loads
    typedef struct packed {
        logic        a_we;
        logic [4:0]  a_addr;
        logic [31:0] a_data;
        logic        b_we;
        logic [4:0]  b_addr;
        logic [31:0] b_data;
    } gpr_wr_t;

    // Outcome of executing one instruction
    typedef struct packed {
        logic        wr_en;
        logic [4:0]  wr_tgt;
        logic [31:0] wr_val;
        logic [31:0] next_fp;
        mem_op_t     mem_op;
        logic [31:0] mem_addr;
        logic [31:0] store_data;
        logic        bad;
        logic        load;
        logic        status_we;
        logic [31:0] status_val;
    } exec_t;

endpackage

### hdl/mseu_ram.sv
// ----------------------------------------------------------------------------
// mseu_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module mseu_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
    end

    // Registered read, old data on a same-address write
    always_ff @(posedge clk)
    begin
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### hdl/mseu_regfile.sv
// ----------------------------------------------------------------------------
// mseu_regfile
// General registers: two banks (instruction writes, load writes), each with
// a copy per read port, a live-bank table, valid bits and a write bypass.
// ----------------------------------------------------------------------------
module mseu_regfile
    import mseu_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic [4:0]  rs_addr,
    input  logic [4:0]  rt_addr,
    input  gpr_wr_t     wr,
    output logic [31:0] rs_data,
    output logic [31:0] rt_data
);

    logic [31:0] a_rs_q;
    logic [31:0] a_rt_q;
    logic [31:0] b_rs_q;
    logic [31:0] b_rt_q;
    logic [4:0]  rs_idx_reg;
    logic [4:0]  rt_idx_reg;
    gpr_wr_t     fwd_reg;
    logic [GPR_COUNT-1:0] valid_reg;
    logic [GPR_COUNT-1:0] valid_next;
    logic [GPR_COUNT-1:0] sel_reg;
    logic [GPR_COUNT-1:0] sel_next;
    logic [31:0] a_rs;
    logic [31:0] a_rt;
    logic [31:0] b_rs;
    logic [31:0] b_rt;

    // Bank A: instruction results
    mseu_ram #(.WIDTH(32), .DEPTH(GPR_COUNT)) u_ram_a_rs (
        .clk   (clk),
        .we    (wr.a_we),
        .waddr (wr.a_addr),
        .wdata (wr.a_data),
        .raddr (rs_addr),
        .rdata (a_rs_q)
    );

    mseu_ram #(.WIDTH(32), .DEPTH(GPR_COUNT)) u_ram_a_rt (
        .clk   (clk),
        .we    (wr.a_we),
        .waddr (wr.a_addr),
        .wdata (wr.a_data),
        .raddr (rt_addr),
        .rdata (a_rt_q)
    );

    // Bank B: delayed load data
    mseu_ram #(.WIDTH(32), .DEPTH(GPR_COUNT)) u_ram_b_rs (
        .clk   (clk),
        .we    (wr.b_we),
        .waddr (wr.b_addr),
        .wdata (wr.b_data),
        .raddr (rs_addr),
        .rdata (b_rs_q)
    );

    mseu_ram #(.WIDTH(32), .DEPTH(GPR_COUNT)) u_ram_b_rt (
        .clk   (clk),
        .we    (wr.b_we),
        .waddr (wr.b_addr),
        .wdata (wr.b_data),
        .raddr (rt_addr),
        .rdata (b_rt_q)
    );

    // Read index and the writes made alongside the read
    always_ff @(posedge clk)
    begin
        rs_idx_reg <= rs_addr;
        rt_idx_reg <= rt_addr;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fwd_reg   <= '0;
            valid_reg <= '0;
            sel_reg   <= '0;
        end
        else
        begin
            fwd_reg   <= wr;
            valid_reg <= valid_next;
            sel_reg   <= sel_next;
        end
    end

    // Valid bits and live-bank table; an instruction write wins
    always_comb
    begin
        valid_next = valid_reg;
        sel_next   = sel_reg;
        if (wr.b_we)
        begin
            valid_next[wr.b_addr] = 1'b1;
            sel_next[wr.b_addr]   = 1'b1;
        end
        if (wr.a_we)
        begin
            valid_next[wr.a_addr] = 1'b1;
            sel_next[wr.a_addr]   = 1'b0;
        end
    end

    // Bypass writes that landed in the cycle the read was issued
    assign a_rs = (fwd_reg.a_we && fwd_reg.a_addr == rs_idx_reg) ? fwd_reg.a_data : a_rs_q;
    assign a_rt = (fwd_reg.a_we && fwd_reg.a_addr == rt_idx_reg) ? fwd_reg.a_data : a_rt_q;
    assign b_rs = (fwd_reg.b_we && fwd_reg.b_addr == rs_idx_reg) ? fwd_reg.b_data : b_rs_q;
    assign b_rt = (fwd_reg.b_we && fwd_reg.b_addr == rt_idx_reg) ? fwd_reg.b_data : b_rt_q;

    // Register zero, never-written registers, then the live bank
    always_comb
    begin
        priority if (rs_idx_reg == GPR_ZERO)
            rs_data = '0;
        else if (!valid_reg[rs_idx_reg])
            rs_data = RESET_GPR;
        else if (sel_reg[rs_idx_reg])
            rs_data = b_rs;
        else
            rs_data = a_rs;

        priority if (rt_idx_reg == GPR_ZERO)
            rt_data = '0;
        else if (!valid_reg[rt_idx_reg])
            rt_data = RESET_GPR;
        else if (sel_reg[rt_idx_reg])
            rt_data = b_rt;
        else
            rt_data = a_rt;
    end

endmodule

### hdl/mseu_alu.sv
// ----------------------------------------------------------------------------
// mseu_alu
// Decode and execute of one held instruction: register result, next fetch
// address, memory access and status write.
// ----------------------------------------------------------------------------
module mseu_alu
    import mseu_pkg::*;
(
    input  logic [31:0] ins,
    input  logic [31:0] vs,
    input  logic [31:0] vt,
    input  logic [31:0] fp,
    input  logic [31:0] status,
    output exec_t       x
);

    logic [5:0]  op;
    logic [4:0]  rs;
    logic [4:0]  rt;
    logic [4:0]  rd;
    logic [4:0]  sa;
    logic [5:0]  fn;
    logic [15:0] imm;
    logic [31:0] simm;
    logic [31:0] pc;
    logic [31:0] ea;
    logic [31:0] jtarget;
    logic [31:0] btarget;

    // Instruction fields
    assign op   = ins[31:26];
    assign rs   = ins[25:21];
    assign rt   = ins[20:16];
    assign rd   = ins[15:11];
    assign sa   = ins[10:6];
    assign fn   = ins[5:0];
    assign imm  = ins[15:0];
    assign simm = {{16{imm[15]}}, imm};

    // Address arithmetic; the delay slot sits at fp
    assign pc      = fp + 32'd4;
    assign ea      = vs + simm;
    assign jtarget = (fp & JUMP_REGION) | {4'd0, ins[25:0], 2'b00};
    assign btarget = fp + {simm[29:0], 2'b00};

    always_comb
    begin
        x         = '0;
        x.mem_op  = MEM_NONE;
        x.next_fp = pc;
        unique case (op)
            OP_SPECIAL:
            begin
                unique case (fn)
                    FN_SLL:
                    begin
                        x.wr_en  = 1'b1;
                        x.wr_tgt = rd;
                        x.wr_val = vt << sa;
                    end
                    FN_JR:
                    begin
                        x.next_fp = vs;
                    end
                    FN_ADDU:
                    begin
                        x.wr_en  = 1'b1;
                        x.wr_tgt = rd;
                        x.wr_val = vs + vt;
                    end
                    FN_OR:
                    begin
                        x.wr_en  = 1'b1;
                        x.wr_tgt = rd;
                        x.wr_val = vs | vt;
                    end
                    FN_SLTU:
                    begin
                        x.wr_en  = 1'b1;
                        x.wr_tgt = rd;
                        x.wr_val = {31'd0, vs < vt};
                    end
                    default:
                    begin
                        x.bad = 1'b1;
                    end
                endcase
            end
            OP_J:
            begin
                x.next_fp = jtarget;
            end
            OP_JAL:
            begin
                x.wr_en   = 1'b1;
                x.wr_tgt  = LINK_REG;
                x.wr_val  = pc;
                x.next_fp = jtarget;
            end
            OP_BNE:
            begin
                if (vs != vt)
                begin
                    x.next_fp = btarget;
                end
            end
            OP_ADDI, OP_ADDI_UNS:
            begin
                // ADDI wraps like the unsigned form
                x.wr_en  = 1'b1;
                x.wr_tgt = rt;
                x.wr_val = ea;
            end
            OP_ANDI:
            begin
                x.wr_en  = 1'b1;
                x.wr_tgt = rt;
                x.wr_val = vs & {16'd0, imm};
            end
            OP_ORI:
            begin
                x.wr_en  = 1'b1;
                x.wr_tgt = rt;
                x.wr_val = vs | {16'd0, imm};
            end
            OP_LUI:
            begin
                x.wr_en  = 1'b1;
                x.wr_tgt = rt;
                x.wr_val = {imm, 16'd0};
            end
            OP_COP0:
            begin
                // only MTC0 is known; only the status register takes it
                if (rs == COP0_MT)
                begin
                    x.status_we  = (rd == STATUS_REG);
                    x.status_val = vt;
                end
                else
                begin
                    x.bad = 1'b1;
                end
            end
            OP_LW:
            begin
                x.mem_op   = MEM_LW;
                x.mem_addr = ea;
                x.load     = 1'b1;
            end
            OP_SB:
            begin
                x.mem_op     = MEM_SB;
                x.mem_addr   = ea;
                x.store_data = vt;
            end
            OP_SH:
            begin
                x.mem_op     = MEM_SH;
                x.mem_addr   = ea;
                x.store_data = vt;
            end
            OP_SW:
            begin
                // word stores are dropped while the cache is isolated
                if (!status[SR_ISOLATE_BIT])
                begin
                    x.mem_op     = MEM_SW;
                    x.mem_addr   = ea;
                    x.store_data = vt;
                end
            end
            default:
            begin
                x.bad = 1'b1;
            end
        endcase
    end

endmodule

### hdl/mips_subset_execute_unit.sv
// ----------------------------------------------------------------------------
// mips_subset_execute_unit
// Partial MIPS I integer core: one fetched word in, one result item out.
// ----------------------------------------------------------------------------
// Usage:
//   cmd channel (cmd_valid / cmd_stall / cmd) carries the instruction word
//   fetched at the previous result's fetch_addr, plus the load data for the
//   previous result's access when that was a load word. The first item after
//   reset carries the word at 0xbfc00000.
//   rsp channel (rsp_valid / rsp_stall / rsp) returns the next fetch address,
//   the memory access to perform and the sticky fault flag.
//   An item is taken into an input register; when it moves on, its word
//   becomes the held instruction, the result register takes the result of
//   the instruction held before it, and rsp_valid rises. While rsp_stall
//   is low one item is taken every cycle. The register file read is issued
//   from the input register as its word moves on, so the held instruction
//   executes against registered read data.
//   While rsp_stall is high and a result is waiting, the result register holds and one further item
//   is still taken into the input register if it is empty; cmd_stall then rises.
//   Reset clears the handshake, the fetch pointer (0xbfc00000), the held
//   instruction, pending load, status and fault; all general registers read
//   0xbeadbeef until written, register zero reads 0. No clearing pass.
// ----------------------------------------------------------------------------
`include "mips_subset_execute_unit_assert.svh"

module mips_subset_execute_unit
    import mseu_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic cmd_valid,
    output logic cmd_stall,
    input  cmd_t cmd,
    output logic rsp_valid,
    input  logic rsp_stall,
    output rsp_t rsp
);

    logic        cmd_vld_reg;
    logic        cmd_vld_next;
    cmd_t        cmd_reg;
    logic        rsp_vld_reg;
    logic        rsp_vld_next;
    rsp_t        rsp_reg;
    rsp_t        rsp_next;
    logic [31:0] fp_reg;
    logic [31:0] fp_next;
    logic [31:0] held_reg;
    logic [31:0] held_next;
    logic [4:0]  pend_reg;
    logic [4:0]  pend_next;
    logic [31:0] status_reg;
    logic [31:0] status_next;
    logic        halted_reg;
    logic        halted_next;
    logic        fire;
    logic        adv;
    logic        take;
    logic [31:0] issue_ins;
    logic [31:0] vs;
    logic [31:0] vt;
    gpr_wr_t     gwr;
    exec_t       x;

    // Handshake: execute when the result register is free or draining
    assign fire      = cmd_vld_reg & (~rsp_vld_reg | ~rsp_stall);
    assign adv       = fire & ~halted_reg;
    assign cmd_stall = cmd_vld_reg & ~fire;
    assign take      = cmd_valid & ~cmd_stall;

    // Register file read for the instruction that executes next
    assign issue_ins = adv ? cmd_reg.fetch_word : held_reg;

    mseu_regfile u_regfile (
        .clk     (clk),
        .rst_n   (rst_n),
        .rs_addr (issue_ins[25:21]),
        .rt_addr (issue_ins[20:16]),
        .wr      (gwr),
        .rs_data (vs),
        .rt_data (vt)
    );

    mseu_alu u_alu (
        .ins    (held_reg),
        .vs     (vs),
        .vt     (vt),
        .fp     (fp_reg),
        .status (status_reg),
        .x      (x)
    );

    // Writebacks; the instruction's value beats the delayed load
    always_comb
    begin
        gwr.a_we   = adv & ~x.bad & x.wr_en & (x.wr_tgt != GPR_ZERO);
        gwr.a_addr = x.wr_tgt;
        gwr.a_data = x.wr_val;
        gwr.b_we   = adv & (pend_reg != GPR_ZERO) & ~(gwr.a_we & (x.wr_tgt == pend_reg));
        gwr.b_addr = pend_reg;
        gwr.b_data = cmd_reg.load_data;
    end

    // Architectural state
    always_comb
    begin
        fp_next     = fp_reg;
        held_next   = held_reg;
        pend_next   = pend_reg;
        status_next = status_reg;
        halted_next = halted_reg;
        if (adv)
        begin
            fp_next     = x.next_fp;
            held_next   = cmd_reg.fetch_word;
            pend_next   = x.load ? held_reg[20:16] : GPR_ZERO;
            halted_next = x.bad;
            if (x.status_we)
            begin
                status_next = x.status_val;
            end
        end
    end

    // Result item; a halted core only repeats its fetch pointer
    always_comb
    begin
        if (halted_reg)
        begin
            rsp_next.fetch_addr = fp_reg;
            rsp_next.mem_op     = MEM_NONE;
            rsp_next.mem_addr   = '0;
            rsp_next.store_data = '0;
            rsp_next.fault      = 1'b1;
        end
        else
        begin
            rsp_next.fetch_addr = x.next_fp;
            rsp_next.mem_op     = x.mem_op;
            rsp_next.mem_addr   = x.mem_addr;
            rsp_next.store_data = x.store_data;
            rsp_next.fault      = x.bad;
        end
    end

    // Valid flags
    always_comb
    begin
        priority if (take)
            cmd_vld_next = 1'b1;
        else if (fire)
            cmd_vld_next = 1'b0;
        else
            cmd_vld_next = cmd_vld_reg;

        priority if (fire)
            rsp_vld_next = 1'b1;
        else if (rsp_vld_reg && !rsp_stall)
            rsp_vld_next = 1'b0;
        else
            rsp_vld_next = rsp_vld_reg;
    end

    // Control and architectural registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_vld_reg <= 1'b0;
            rsp_vld_reg <= 1'b0;
            fp_reg      <= RESET_PC;
            held_reg    <= '0;
            pend_reg    <= GPR_ZERO;
            status_reg  <= '0;
            halted_reg  <= 1'b0;
        end
        else
        begin
            cmd_vld_reg <= cmd_vld_next;
            rsp_vld_reg <= rsp_vld_next;
            fp_reg      <= fp_next;
            held_reg    <= held_next;
            pend_reg    <= pend_next;
            status_reg  <= status_next;
            halted_reg  <= halted_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            cmd_reg <= cmd;
        end
        if (fire)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp_valid = rsp_vld_reg;
    assign rsp       = rsp_reg;

    // Checks
    `MSEU_ASSERT_NEXT(a_halt_sticky, halted_reg, halted_reg)
    `MSEU_ASSERT_NOW(a_fault_no_access, rsp_vld_reg && rsp_reg.fault, rsp_reg.mem_op == MEM_NONE)
    `MSEU_ASSERT_NOW(a_pend_after_lw, pend_reg != GPR_ZERO, rsp_reg.mem_op == MEM_LW)

endmodule
